>>> rtl/core/crbp_pkg.sv
// Shared types, constants and code-building functions of the cluster residual bit packer.
package crbp_pkg;

  localparam int NumSegs = 6;
  localparam int SegIdxW = 3;
  localparam int SegValW = 16;
  localparam int SegLenW = 5;
  localparam int AccW    = 32;
  localparam int CntW    = 6;
  localparam int QDepth  = 4;
  localparam int QPtrW   = 2;
  localparam int QCntW   = 3;

  localparam logic [5:0]         SliceMax  = 6'd35;
  localparam logic [SegLenW-1:0] SliceW    = 5'd6;
  localparam logic [SegLenW-1:0] WidthMax  = 5'd16;
  localparam logic [SegLenW-1:0] SignedMin = 5'd2;
  localparam logic [SegLenW-1:0] ChargeMin = 5'd1;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_TRACK  = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    CFG_TIME_BITS   = 3'd0,
    CFG_PAD_BITS    = 3'd1,
    CFG_CHARGE_BITS = 3'd2,
    CFG_SHAPE_BITS  = 3'd3,
    CFG_WRITE_SHAPE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [SegValW-1:0] val;
    logic [SegLenW-1:0] len;
  } seg_t;

  typedef struct packed {
    seg_t seg;
    logic sat;
  } code_t;

  // one packing job handed from front to back
  typedef struct packed {
    logic                    flush;
    logic [SegIdxW-1:0]      nseg;
    seg_t [NumSegs-1:0]      segs;
    logic                    sat;
    logic                    slice_err;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       saturated;
    logic       slice_error;
    logic       last;
  } res_t;

  function automatic logic [SegLenW-1:0] clamp_width(logic [SegLenW-1:0] v,
                                                     logic [SegLenW-1:0] lo);
    logic [SegLenW-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > WidthMax) begin
      r = WidthMax;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // saturated magnitude of m bits, optionally led by a sign bit (1 = not negative)
  function automatic code_t mag_code(logic [16:0] x, logic [SegLenW-1:0] m,
                                     logic with_sign);
    logic        neg;
    logic [16:0] mag;
    logic [16:0] lim;
    code_t       c;
    neg = x[16];
    mag = neg ? (~x + 17'd1) : x;
    lim = (17'd1 << m) - 17'd1;
    c.sat = (mag > lim);
    c.seg.val = c.sat ? lim[SegValW-1:0] : mag[SegValW-1:0];
    c.seg.len = m;
    if (with_sign) begin
      c.seg.val = c.seg.val | (SegValW'(!neg) << m);
      c.seg.len = m + 5'd1;
    end
    return c;
  endfunction

endpackage

>>> rtl/core/crbp_front.sv
// Front end: configuration registers, slice coding state and request classification.
module crbp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [4:0]          cfg_data,
  input  logic                accept,
  input  logic [1:0]          in_operation,
  input  logic                in_present,
  input  logic [5:0]          in_slice_number,
  input  logic signed [16:0]  in_time_delta,
  input  logic signed [16:0]  in_pad_delta,
  input  logic signed [16:0]  in_charge_delta,
  input  logic signed [16:0]  in_shape_y,
  input  logic signed [16:0]  in_shape_z,
  input  logic [7:0]          in_track_byte,
  output crbp_pkg::cmd_t      cmd
);

  logic [4:0] time_bits_r, pad_bits_r, charge_bits_r, shape_bits_r;
  logic       write_shape_r;
  logic [5:0] prev_slice_r;
  logic       slice_sent_r;

  logic [4:0]      tw, pw, cw, sw;
  crbp_pkg::code_t c_time, c_pad, c_charge, c_sy, c_sz;
  crbp_pkg::seg_t  hdr;
  logic            slice_ok;
  logic            rec_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_bits_r   <= 5'd10;
      pad_bits_r    <= 5'd8;
      charge_bits_r <= 5'd10;
      shape_bits_r  <= 5'd6;
      write_shape_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (crbp_pkg::cfg_reg_t'(cfg_index))
        crbp_pkg::CFG_TIME_BITS:   time_bits_r   <= cfg_data;
        crbp_pkg::CFG_PAD_BITS:    pad_bits_r    <= cfg_data;
        crbp_pkg::CFG_CHARGE_BITS: charge_bits_r <= cfg_data;
        crbp_pkg::CFG_SHAPE_BITS:  shape_bits_r  <= cfg_data;
        crbp_pkg::CFG_WRITE_SHAPE: write_shape_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tw = crbp_pkg::clamp_width(time_bits_r, crbp_pkg::SignedMin) - 5'd1;
    pw = crbp_pkg::clamp_width(pad_bits_r, crbp_pkg::SignedMin) - 5'd1;
    cw = crbp_pkg::clamp_width(charge_bits_r, crbp_pkg::ChargeMin);
    sw = crbp_pkg::clamp_width(shape_bits_r, crbp_pkg::SignedMin) - 5'd1;
    c_time   = crbp_pkg::mag_code(in_time_delta, tw, 1'b1);
    c_pad    = crbp_pkg::mag_code(in_pad_delta, pw, 1'b1);
    c_charge = crbp_pkg::mag_code(in_charge_delta, cw, 1'b0);
    c_sy     = crbp_pkg::mag_code(in_shape_y, sw, 1'b1);
    c_sz     = crbp_pkg::mag_code(in_shape_z, sw, 1'b1);
    slice_ok = (in_slice_number <= crbp_pkg::SliceMax);
    rec_ok   = (crbp_pkg::op_t'(in_operation) == crbp_pkg::OP_RECORD) && in_present
               && slice_ok;

    // present bit merged with the slice code
    if (!slice_sent_r) begin
      hdr.val = 16'({1'b1, in_slice_number});
      hdr.len = crbp_pkg::SliceW + 5'd1;
    end else if (in_slice_number == prev_slice_r) begin
      hdr.val = 16'(2'b10);
      hdr.len = 5'd2;
    end else begin
      hdr.val = 16'({2'b11, in_slice_number});
      hdr.len = crbp_pkg::SliceW + 5'd2;
    end

    cmd = '0;
    unique case (crbp_pkg::op_t'(in_operation))
      crbp_pkg::OP_RECORD: begin
        if (!in_present) begin
          cmd.nseg         = 3'd1;
          cmd.segs[0].val  = '0;
          cmd.segs[0].len  = 5'd1;
        end else if (!slice_ok) begin
          cmd.slice_err = 1'b1;
        end else begin
          cmd.segs[0] = hdr;
          cmd.segs[1] = c_time.seg;
          cmd.segs[2] = c_pad.seg;
          cmd.segs[3] = c_charge.seg;
          cmd.sat     = c_time.sat | c_pad.sat | c_charge.sat;
          if (write_shape_r) begin
            cmd.segs[4] = c_sy.seg;
            cmd.segs[5] = c_sz.seg;
            cmd.sat     = cmd.sat | c_sy.sat | c_sz.sat;
            cmd.nseg    = 3'd6;
          end else begin
            cmd.nseg    = 3'd4;
          end
        end
      end
      crbp_pkg::OP_TRACK: begin
        cmd.flush       = 1'b1;
        cmd.nseg        = 3'd1;
        cmd.segs[0].val = 16'(in_track_byte);
        cmd.segs[0].len = 5'd8;
      end
      crbp_pkg::OP_FINISH: begin
        cmd.flush = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_sent_r <= 1'b0;
      prev_slice_r <= '0;
    end else if (accept) begin
      if (rec_ok) begin
        slice_sent_r <= 1'b1;
        prev_slice_r <= in_slice_number;
      end else if (crbp_pkg::op_t'(in_operation) == crbp_pkg::OP_TRACK) begin
        slice_sent_r <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/crbp_cmd_queue.sv
// Four-entry request queue between front end and bit packer.
module crbp_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  crbp_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output crbp_pkg::cmd_t dout,
  output logic           empty
);

  crbp_pkg::cmd_t                   q_r [crbp_pkg::QDepth];
  logic [crbp_pkg::QPtrW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [crbp_pkg::QCntW-1:0]       cnt_r;
  logic                             do_push, do_pop;

  assign full    = (cnt_r == crbp_pkg::QCntW'(crbp_pkg::QDepth));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/crbp_back.sv
// Back end: bit accumulator, byte emission with last marking and result queue.
module crbp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  crbp_pkg::cmd_t cmd,
  input  logic           cmd_empty,
  output logic           cmd_pop,
  input  logic           pop,
  output logic           empty,
  output crbp_pkg::res_t res
);

  localparam logic [crbp_pkg::CntW-1:0] ByteBits = 6'd8;
  localparam logic [crbp_pkg::CntW-1:0] AccBits  = crbp_pkg::CntW'(crbp_pkg::AccW);

  logic [crbp_pkg::AccW-1:0]    acc_r, acc_nxt, acc_e;
  logic [crbp_pkg::CntW-1:0]    cnt_r, cnt_nxt, cnt_e, sh;
  logic                         active_r, active_nxt;
  crbp_pkg::cmd_t               cur_r, cur_nxt;
  logic [crbp_pkg::SegIdxW-1:0] seg_idx_r, seg_idx_nxt;
  logic                         hold_v_r, hold_v_nxt;
  logic [7:0]                   hold_byte_r, hold_byte_nxt;

  crbp_pkg::seg_t seg;
  logic           emit, app, done, load;
  logic           rq_push, rq_full, rq_pop;
  crbp_pkg::res_t rq_din;

  crbp_pkg::res_t             rq_r [crbp_pkg::QDepth];
  logic [crbp_pkg::QPtrW-1:0] rq_wr_r, rq_rd_r;
  logic [crbp_pkg::QCntW-1:0] rq_cnt_r;

  always_comb begin
    seg = (seg_idx_r < crbp_pkg::SegIdxW'(crbp_pkg::NumSegs)) ? cur_r.segs[seg_idx_r] : '0;

    emit  = active_r && (cnt_r >= ByteBits) && (!hold_v_r || !rq_full);
    acc_e = emit ? (acc_r << 8) : acc_r;
    cnt_e = emit ? (cnt_r - ByteBits) : cnt_r;
    app   = active_r && (seg_idx_r < cur_r.nseg)
            && ((7'(cnt_e) + 7'(seg.len)) <= 7'(AccBits));
    sh    = AccBits - cnt_e - 6'(seg.len);
    done  = active_r && (seg_idx_r == cur_r.nseg) && (cnt_r < ByteBits) && !rq_full;
    load  = !cmd_empty && (!active_r || done);

    acc_nxt       = app ? (acc_e | (crbp_pkg::AccW'(seg.val) << sh)) : acc_e;
    cnt_nxt       = app ? (cnt_e + 6'(seg.len)) : cnt_e;
    seg_idx_nxt   = app ? (seg_idx_r + 1'b1) : seg_idx_r;
    cur_nxt       = cur_r;
    active_nxt    = active_r;
    hold_v_nxt    = hold_v_r;
    hold_byte_nxt = hold_byte_r;
    rq_push       = 1'b0;
    rq_din        = '0;

    if (emit) begin
      hold_v_nxt    = 1'b1;
      hold_byte_nxt = acc_r[crbp_pkg::AccW-1 -: 8];
      rq_push       = hold_v_r;
      rq_din        = '{out_byte: hold_byte_r, byte_valid: 1'b1, saturated: cur_r.sat,
                        slice_error: cur_r.slice_err, last: 1'b0};
    end else if (done) begin
      hold_v_nxt = 1'b0;
      rq_push    = 1'b1;
      rq_din     = '{out_byte: hold_v_r ? hold_byte_r : 8'd0, byte_valid: hold_v_r,
                     saturated: cur_r.sat, slice_error: cur_r.slice_err, last: 1'b1};
      active_nxt = 1'b0;
    end

    if (load) begin
      cur_nxt     = cmd;
      seg_idx_nxt = '0;
      active_nxt  = 1'b1;
      // pad the partial byte with zeros
      if (cmd.flush && (cnt_r != '0)) begin
        cnt_nxt = ByteBits;
      end
    end
  end

  assign cmd_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      cnt_r     <= '0;
      active_r  <= 1'b0;
      seg_idx_r <= '0;
      hold_v_r  <= 1'b0;
    end else begin
      acc_r     <= acc_nxt;
      cnt_r     <= cnt_nxt;
      active_r  <= active_nxt;
      seg_idx_r <= seg_idx_nxt;
      hold_v_r  <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    hold_byte_r <= hold_byte_nxt;
  end

  // result queue
  assign rq_full = (rq_cnt_r == crbp_pkg::QCntW'(crbp_pkg::QDepth));
  assign empty   = (rq_cnt_r == '0);
  assign rq_pop  = pop && !empty;
  assign res     = rq_r[rq_rd_r];

  always_ff @(posedge clk) begin
    if (rq_push) begin
      rq_r[rq_wr_r] <= rq_din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_r  <= '0;
      rq_rd_r  <= '0;
      rq_cnt_r <= '0;
    end else begin
      if (rq_push) begin
        rq_wr_r <= rq_wr_r + 1'b1;
      end
      if (rq_pop) begin
        rq_rd_r <= rq_rd_r + 1'b1;
      end
      if (rq_push && !rq_pop) begin
        rq_cnt_r <= rq_cnt_r + 1'b1;
      end else if (rq_pop && !rq_push) begin
        rq_cnt_r <= rq_cnt_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_seg_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (seg_idx_r <= cur_r.nseg))
    else $error("segment index past request end");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= AccBits)
    else $error("accumulator overfilled");

  a_load_partial: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (cnt_r < ByteBits))
    else $error("new request loaded with a whole byte pending");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    rq_push |-> !rq_full)
    else $error("result queue overflow");
`endif

endmodule

>>> rtl/core/cluster_residual_bit_packer.sv
// Top level of the cluster residual bit packer.
//
//  channel | ports                                     | handshake
//  --------+-------------------------------------------+---------------------
//  in      | in_operation .. in_track_byte             | push & !full
//  out     | out_byte, out_byte_valid, out_saturated,  | pop & !empty
//          | out_slice_error, out_last                 |
//  cfg     | cfg_index, cfg_data                       | cfg_valid & cfg_ready
//
// A request is classified in the cycle it is pushed; the packer then appends its code
// segments one at a time, emits any whole bytes left after the last segment, and closes
// the request in a step that overlaps the next load.
// Reset is synchronous; no clearing pass. Four-entry queues sit on both sides of the
// packer, so full and empty stall each side independently.
module cluster_residual_bit_packer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         in_operation,
  input  logic               in_present,
  input  logic [5:0]         in_slice_number,
  input  logic signed [16:0] in_time_delta,
  input  logic signed [16:0] in_pad_delta,
  input  logic signed [16:0] in_charge_delta,
  input  logic signed [16:0] in_shape_y,
  input  logic signed [16:0] in_shape_z,
  input  logic [7:0]         in_track_byte,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         out_byte,
  output logic               out_byte_valid,
  output logic               out_saturated,
  output logic               out_slice_error,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [4:0]         cfg_data
);

  crbp_pkg::cmd_t front_cmd, back_cmd;
  crbp_pkg::res_t res;
  logic           accept, cmd_empty, cmd_pop;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  crbp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .accept          (accept),
    .in_operation    (in_operation),
    .in_present      (in_present),
    .in_slice_number (in_slice_number),
    .in_time_delta   (in_time_delta),
    .in_pad_delta    (in_pad_delta),
    .in_charge_delta (in_charge_delta),
    .in_shape_y      (in_shape_y),
    .in_shape_z      (in_shape_z),
    .in_track_byte   (in_track_byte),
    .cmd             (front_cmd)
  );

  crbp_cmd_queue u_cmd_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .din   (front_cmd),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (back_cmd),
    .empty (cmd_empty)
  );

  crbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (back_cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .res       (res)
  );

  assign out_byte        = res.out_byte;
  assign out_byte_valid  = res.byte_valid;
  assign out_saturated   = res.saturated;
  assign out_slice_error = res.slice_error;
  assign out_last        = res.last;

endmodule
